/* rtl/core/assert_macros.svh */
// Assertion macros shared by the permutation rank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/prk_pkg.sv */
// Package with the types, constants and helper functions of the permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

package prk_pkg;

    localparam int unsigned MAX_DIGITS = 9;
    localparam int unsigned NUM_W      = 30;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned RANK_W     = 19;

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    typedef logic [DIGIT_W-1:0]                  t_digit;
    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  t_digit_vec;

    // Payload handed from one cell to the next.
    typedef struct packed {
        logic [NUM_W-1:0]  num;     // remaining high part of the number
        t_digit_vec        digits;  // digits split off so far, units digit at index 0
        logic [RANK_W-1:0] rank;    // partial rank
    } t_stage;

    // Factorial table; index 0 holds zero, since the units digit adds nothing.
    function automatic logic [RANK_W-1:0] fact(input int unsigned n);
        logic [RANK_W-1:0] f;
        case (n)
            0:       f = 19'd0;
            1:       f = 19'd1;
            2:       f = 19'd2;
            3:       f = 19'd6;
            4:       f = 19'd24;
            5:       f = 19'd120;
            6:       f = 19'd720;
            7:       f = 19'd5040;
            8:       f = 19'd40320;
            9:       f = 19'd362880;
            default: f = 19'd0;
        endcase
        return f;
    endfunction

    // Counts the digits selected by mask that are strictly smaller than v.
    function automatic t_digit count_lower(input t_digit_vec d, input t_digit v,
                                           input logic [MAX_DIGITS-1:0] mask);
        t_digit cnt;
        cnt = '0;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (mask[j] && (d[j] < v)) begin
                cnt = cnt + t_digit'(1);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/prk_cell.sv */
// One cell of the ranking chain: splits off one decimal digit and ranks the digit before it.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module prk_cell #(
    parameter int unsigned POS = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // Upstream side
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire prk_pkg::t_stage i_stage,
    // Downstream side
    output logic                 o_valid,
    input  wire logic            i_ready,
    output prk_pkg::t_stage      o_stage
);

    // The digit ranked here is the one split off by the previous cell.
    localparam int unsigned CNT_POS = (POS == 0) ? 0 : POS - 1;
    localparam logic [prk_pkg::MAX_DIGITS-1:0] LOWER_MASK =
        prk_pkg::MAX_DIGITS'((1 << CNT_POS) - 1);
    localparam logic [prk_pkg::RANK_W-1:0] CNT_WEIGHT = prk_pkg::fact(CNT_POS);
    localparam logic [prk_pkg::RANK_W-1:0] RANK_LIM =
        (POS == 0) ? prk_pkg::RANK_W'(1) : prk_pkg::fact(POS);

    logic                            r_valid;
    prk_pkg::t_stage                 r_stage;
    prk_pkg::t_stage                 n_stage;

    logic [61:0]                     w_prod;
    logic [prk_pkg::NUM_W-1:0]       w_quot;
    logic [prk_pkg::NUM_W-1:0]       w_times10;
    logic [prk_pkg::NUM_W-1:0]       w_rem;
    prk_pkg::t_digit                 w_cnt;

    // The cell takes a new request whenever its register is empty or drains this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    // Divide by ten with a reciprocal multiply, remainder by shift-and-add back.
    always_comb begin
        w_prod    = {32'd0, i_stage.num} * {30'd0, prk_pkg::RECIP10};
        w_quot    = prk_pkg::NUM_W'(w_prod[61:prk_pkg::RECIP10_SHIFT]);
        w_times10 = {w_quot[prk_pkg::NUM_W-4:0], 3'b000} + {w_quot[prk_pkg::NUM_W-2:0], 1'b0};
        w_rem     = i_stage.num - w_times10;
    end

    // Rank the previous digit against the digits below it and record the new digit.
    always_comb begin
        w_cnt          = prk_pkg::count_lower(i_stage.digits, i_stage.digits[CNT_POS],
                                              LOWER_MASK);
        n_stage        = i_stage;
        n_stage.num    = w_quot;
        n_stage.digits[POS] = w_rem[prk_pkg::DIGIT_W-1:0];
        n_stage.rank   = i_stage.rank
                       + prk_pkg::RANK_W'({15'd0, w_cnt} * CNT_WEIGHT);
    end

    // Valid flag of the cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the cell register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    `ASSERT_IMPL(a_digit_decimal, i_clk, i_rst_n, r_valid, r_stage.digits[POS] <= 4'd9)
    `ASSERT_IMPL(a_rank_bound, i_clk, i_rst_n, r_valid, r_stage.rank < RANK_LIM)
    `ASSERT_NEXT(a_empty_when_no_input, i_clk, i_rst_n, o_ready && !i_valid, !r_valid)

endmodule

`default_nettype wire

/* rtl/core/permutation_rank_9_digit.sv */
// Top level of the permutation rank block: a chain of digit cells and an output register.
//
// Usage:
//   Input channel: i_perm_number with i_in_valid / o_in_ready. The number holds
//   the permutation digits, most significant first; only its low DIGITS decimal
//   digits are ranked, and missing high digits count as zero.
//   Output channel: o_perm_rank with o_out_valid / i_out_ready, the
//   lexicographic rank (0 for 123456789).
//   Path: an accepted request passes through one cell per decimal digit and
//   then the output register before o_out_valid rises.
//   Throughput: one request per cycle while the receiver takes results; each
//   cell holds one request, so up to DIGITS + 1 requests are in flight.
//   Stall: when i_out_ready is low the output holds its result and the chain
//   fills up; o_in_ready drops only once every cell and the output register
//   hold a request.
//   Reset: synchronous, active low; it empties every cell and the output
//   register. The payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module permutation_rank_9_digit #(
    parameter int unsigned DIGITS = 9
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [prk_pkg::NUM_W-1:0]     i_perm_number,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [prk_pkg::RANK_W-1:0]         o_perm_rank
);

    localparam int unsigned LAST = DIGITS - 1;
    localparam logic [prk_pkg::MAX_DIGITS-1:0] LAST_MASK =
        prk_pkg::MAX_DIGITS'((1 << LAST) - 1);
    localparam logic [prk_pkg::RANK_W-1:0] LAST_WEIGHT = prk_pkg::fact(LAST);
    localparam logic [prk_pkg::RANK_W-1:0] MAX_RANK =
        prk_pkg::fact(DIGITS) - prk_pkg::RANK_W'(1);

    logic                           w_valid [DIGITS+1];
    logic                           w_ready [DIGITS+1];
    prk_pkg::t_stage                w_stage [DIGITS+1];

    logic                           r_out_valid;
    logic [prk_pkg::RANK_W-1:0]     r_rank;
    logic [prk_pkg::RANK_W-1:0]     n_rank;
    prk_pkg::t_digit                w_cnt;

    // Entry of the chain: the whole number, no digits yet, rank zero.
    assign w_valid[0]           = i_in_valid;
    assign w_stage[0].num       = i_perm_number;
    assign w_stage[0].digits    = '0;
    assign w_stage[0].rank      = '0;
    assign o_in_ready           = w_ready[0];

    // One cell per decimal position.
    for (genvar k = 0; k < DIGITS; k++) begin : g_cell
        prk_cell #(
            .POS (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_stage (w_stage[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_stage (w_stage[k+1])
        );
    end

    // The last cell's digit is ranked on the way into the output register.
    always_comb begin
        w_cnt  = prk_pkg::count_lower(w_stage[DIGITS].digits, w_stage[DIGITS].digits[LAST],
                                      LAST_MASK);
        n_rank = w_stage[DIGITS].rank
               + prk_pkg::RANK_W'({15'd0, w_cnt} * LAST_WEIGHT);
    end

    assign w_ready[DIGITS] = !r_out_valid || i_out_ready;

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[DIGITS]) begin
            r_out_valid <= w_valid[DIGITS];
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_ready[DIGITS] && w_valid[DIGITS]) begin
            r_rank <= n_rank;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_perm_rank = r_rank;

    `ASSERT_IMPL(a_rank_in_range, i_clk, i_rst_n, r_out_valid, r_rank <= MAX_RANK)
    `ASSERT_IMPL(a_ready_when_drained, i_clk, i_rst_n, i_out_ready, o_in_ready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_perm_rank))

endmodule

`default_nettype wire
